// ----- design/ecb_pkg.sv -----
// Shared types and constants of the event counter bank.
package ecb_pkg;

	localparam int NUM_SLOTS_DEF   = 16;
	localparam int HOLDER_BITS_DEF = 8;
	localparam int COUNT_W         = 64;

	localparam logic [1:0] RDY_READ  = 2'b01;
	localparam logic [1:0] RDY_WRITE = 2'b10;

	typedef enum logic [2:0] {
		ACT_CREATE   = 3'd0,
		ACT_RETAIN   = 3'd1,
		ACT_CLOSE    = 3'd2,
		ACT_NONBLOCK = 3'd3,
		ACT_READ     = 3'd4,
		ACT_WRITE    = 3'd5,
		ACT_POLL     = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_FREE     = 3'd1,
		ST_BAD_SLOT    = 3'd2,
		ST_WOULD_BLOCK = 3'd3,
		ST_MUST_WAIT   = 3'd4,
		ST_OVERFLOW    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_EXEC
	} seq_state_t;

endpackage

// ----- design/ecb_in_if.sv -----
// Request channel of the event counter bank.
interface ecb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  slot;
	logic [63:0] value;
	logic        semaphore_mode;
	logic        nonblock_mode;
	logic [1:0]  poll_mask;

	modport source (
		output valid, action, slot, value, semaphore_mode, nonblock_mode, poll_mask,
		input  ready
	);
	modport sink (
		input  valid, action, slot, value, semaphore_mode, nonblock_mode, poll_mask,
		output ready
	);
endinterface

// ----- design/ecb_out_if.sv -----
// Response channel of the event counter bank.
interface ecb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic [63:0] read_value;
	logic [1:0]  ready_mask;

	modport source (
		output valid, status, slot_out, read_value, ready_mask,
		input  ready
	);
	modport sink (
		input  valid, status, slot_out, read_value, ready_mask,
		output ready
	);
endinterface

// ----- design/event_counter_bank_unit.sv -----
// Top level of the event counter bank: sequencer, shared adder and slot RAM.
//
// A bank of NUM_SLOTS event counters. Each request reads one slot record from the slot RAM,
// works it through a single shared 65-bit adder and writes it back. Retain, close,
// set_nonblock, read, write and poll first do the registered RAM read, then compute and write
// back in the execute state, which waits while an earlier response is stalled. Create searches
// the in-use flags one slot per cycle starting at slot 0 and stops at the lowest free slot or
// at the last slot. The request side is not ready while a word is in work; a finished
// response waits in the output register while the next request is taken. No clearing pass
// is needed after reset.
module event_counter_bank_unit
	import ecb_pkg::*;
#(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int HOLDER_BITS = HOLDER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ecb_in_if.sink     req,
	ecb_out_if.source  rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int REC_W = COUNT_W + 2 + HOLDER_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
	localparam logic [HOLDER_BITS-1:0] HOLDER_MAX = '1;

	seq_state_t state_q, state_d;

	logic [NUM_SLOTS-1:0] slot_used_q;
	logic                 out_valid_q;
	status_t              status_q;
	logic [3:0]           slot_out_q;
	logic [COUNT_W-1:0]   read_value_q;
	logic [1:0]           ready_mask_q;

	action_t              act_q;
	logic [3:0]           slot_q;
	logic [COUNT_W-1:0]   value_q;
	logic                 sem_q;
	logic                 nb_q;
	logic [1:0]           mask_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 found_q;

	logic                 accept;
	logic                 out_free;
	logic                 commit;
	logic                 scan_stop;
	logic                 req_valid_slot;

	logic                 ram_we;
	logic [REC_W-1:0]     ram_wdata;
	logic [REC_W-1:0]     ram_rdata;

	logic [COUNT_W-1:0]     rec_count;
	logic                   rec_take_one;
	logic                   rec_no_wait;
	logic [HOLDER_BITS-1:0] rec_holders;

	logic [COUNT_W-1:0]   add_a;
	logic [COUNT_W-1:0]   add_b;
	logic [COUNT_W:0]     add_sum;

	status_t              status_d;
	logic [3:0]           slot_out_d;
	logic [COUNT_W-1:0]   read_value_d;
	logic [1:0]           ready_mask_d;
	logic                 used_set;
	logic                 used_clr;
	logic [1:0]           poll_m;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign commit   = (state_q == SEQ_EXEC) && out_free;
	assign scan_stop = !slot_used_q[idx_q] || (idx_q == LAST_IDX);
	assign req_valid_slot = (32'(req.slot) < NUM_SLOTS) && slot_used_q[IDX_W'(req.slot)];

	assign req.ready      = (state_q == SEQ_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot_out   = slot_out_q;
	assign rsp.read_value = read_value_q;
	assign rsp.ready_mask = ready_mask_q;

	ecb_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (IDX_W'(req.slot)),
		.rdata (ram_rdata)
	);

	assign rec_count    = ram_rdata[REC_W-1 -: COUNT_W];
	assign rec_take_one = ram_rdata[HOLDER_BITS+1];
	assign rec_no_wait  = ram_rdata[HOLDER_BITS];
	assign rec_holders  = ram_rdata[HOLDER_BITS-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					state_d = (action_t'(req.action) == ACT_CREATE) ? SEQ_SCAN : SEQ_EXEC;
				end
			end
			SEQ_SCAN: begin
				if (scan_stop) begin
					state_d = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		unique case (act_q)
			ACT_RETAIN: begin
				add_a = COUNT_W'(rec_holders);
				add_b = COUNT_W'(1);
			end
			ACT_CLOSE: begin
				add_a = COUNT_W'(rec_holders);
				add_b = '1;
			end
			ACT_READ: begin
				add_a = rec_count;
				add_b = '1;
			end
			default: begin
				add_a = rec_count;
				add_b = value_q;
			end
		endcase
		add_sum = {1'b0, add_a} + {1'b0, add_b};
	end

	always_comb begin
		status_d     = ST_OK;
		slot_out_d   = slot_q;
		read_value_d = '0;
		ready_mask_d = '0;
		ram_wdata    = ram_rdata;
		ram_we       = 1'b0;
		used_set     = 1'b0;
		used_clr     = 1'b0;
		poll_m       = (mask_q != 2'b00) ? mask_q : (RDY_READ | RDY_WRITE);
		if (act_q == ACT_CREATE) begin
			if (found_q) begin
				ram_wdata  = {COUNT_W'(value_q[31:0]), sem_q, nb_q, HOLDER_BITS'(1)};
				ram_we     = 1'b1;
				used_set   = 1'b1;
				slot_out_d = 4'(idx_q);
			end else begin
				status_d   = ST_NO_FREE;
				slot_out_d = 4'd0;
			end
		end else if (!valid_q) begin
			status_d = ST_BAD_SLOT;
		end else begin
			unique case (act_q)
				ACT_RETAIN: begin
					if (rec_holders != HOLDER_MAX) begin
						ram_wdata[HOLDER_BITS-1:0] = add_sum[HOLDER_BITS-1:0];
						ram_we = 1'b1;
					end
				end
				ACT_CLOSE: begin
					if (rec_holders > HOLDER_BITS'(1)) begin
						ram_wdata[HOLDER_BITS-1:0] = add_sum[HOLDER_BITS-1:0];
						ram_we = 1'b1;
					end else begin
						used_clr = 1'b1;
					end
				end
				ACT_NONBLOCK: begin
					ram_wdata[HOLDER_BITS] = nb_q;
					ram_we = 1'b1;
				end
				ACT_READ: begin
					if (rec_count == '0) begin
						status_d = rec_no_wait ? ST_WOULD_BLOCK : ST_MUST_WAIT;
					end else if (rec_take_one) begin
						read_value_d = COUNT_W'(1);
						ram_wdata[REC_W-1 -: COUNT_W] = add_sum[COUNT_W-1:0];
						ram_we = 1'b1;
					end else begin
						read_value_d = rec_count;
						ram_wdata[REC_W-1 -: COUNT_W] = '0;
						ram_we = 1'b1;
					end
				end
				ACT_WRITE: begin
					if (add_sum[COUNT_W]) begin
						status_d = ST_OVERFLOW;
					end else begin
						ram_wdata[REC_W-1 -: COUNT_W] = add_sum[COUNT_W-1:0];
						ram_we = 1'b1;
					end
				end
				ACT_POLL: begin
					ready_mask_d[0] = (rec_count != '0) && poll_m[0];
					ready_mask_d[1] = poll_m[1];
				end
				default: status_d = ST_BAD_SLOT;
			endcase
		end
		ram_we = ram_we && commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			slot_used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
				if (used_set) begin
					slot_used_q[idx_q] <= 1'b1;
				end
				if (used_clr) begin
					slot_used_q[idx_q] <= 1'b0;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action_t'(req.action);
			slot_q  <= req.slot;
			value_q <= req.value;
			sem_q   <= req.semaphore_mode;
			nb_q    <= req.nonblock_mode;
			mask_q  <= req.poll_mask;
			valid_q <= req_valid_slot;
			idx_q   <= (action_t'(req.action) == ACT_CREATE) ? '0 : IDX_W'(req.slot);
		end else if (state_q == SEQ_SCAN) begin
			found_q <= !slot_used_q[idx_q];
			if (!scan_stop) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (commit) begin
			status_q     <= status_d;
			slot_out_q   <= slot_out_d;
			read_value_q <= read_value_d;
			ready_mask_q <= ready_mask_d;
		end
	end

endmodule

// ----- design/ecb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ecb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ecb_checker.sv -----
// Port-level checks of the event counter bank and their binding to the top level.
module ecb_checker
	import ecb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [3:0]  rsp_slot_out,
	input logic [63:0] rsp_read_value,
	input logic [1:0]  rsp_ready_mask
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot_out) && $stable(rsp_read_value) && $stable(rsp_ready_mask))
		else $error("response word changed while stalled");

	// The bank works on one request word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a word is in work");

	// Only a successful read returns a value.
	a_read_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_read_value != 64'd0) |-> rsp_status == ST_OK)
		else $error("read value returned with an error status");

	// Only a successful poll reports readiness.
	a_ready_mask_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_ready_mask != 2'b00) |-> rsp_status == ST_OK)
		else $error("ready mask reported with an error status");

	// A full bank always answers with slot zero.
	a_no_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NO_FREE) |-> rsp_slot_out == 4'd0)
		else $error("full bank reported a nonzero slot");

endmodule

bind event_counter_bank_unit ecb_checker u_ecb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_slot_out   (rsp.slot_out),
	.rsp_read_value (rsp.read_value),
	.rsp_ready_mask (rsp.ready_mask)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the event counter bank with directed and random request words.
module tb;
	import ecb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam logic [7:0] HOLDER_MAX = 8'(2 ** HOLDER_BITS_DEF - 1);
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  slot;
		logic [63:0] value;
		logic        semaphore_mode;
		logic        nonblock_mode;
		logic [1:0]  poll_mask;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot_out;
		logic [63:0] read_value;
		logic [1:0]  ready_mask;
	} result_t;

	logic clk;
	logic arst_n;

	ecb_in_if  req_if ();
	ecb_out_if rsp_if ();

	event_counter_bank_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	bit          in_use        [SLOTS];
	logic [63:0] tally         [SLOTS];
	bit          one_at_a_time [SLOTS];
	bit          fail_fast     [SLOTS];
	logic [7:0]  refs          [SLOTS];

	result_t pending_results[$];
	int      gap_max = 13;
	int      stall_max = 13;
	int      words_sent = 0;
	int      words_checked = 0;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      status_seen [8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void release_slot(int s);
		in_use[s] = 1'b0;
		tally[s] = '0;
		one_at_a_time[s] = 1'b0;
		fail_fast[s] = 1'b0;
		refs[s] = '0;
	endfunction

	function automatic result_t bank_apply(request_t w);
		result_t r;
		bit found;
		logic [1:0] interest;
		r.status = ST_OK;
		r.slot_out = w.slot;
		r.read_value = '0;
		r.ready_mask = '0;
		found = 1'b0;
		if (w.action == ACT_CREATE) begin
			r.slot_out = '0;
			r.status = ST_NO_FREE;
			for (int s = 0; s < SLOTS; s++) begin
				if (!found && !in_use[s]) begin
					found = 1'b1;
					in_use[s] = 1'b1;
					tally[s] = {32'd0, w.value[31:0]};
					one_at_a_time[s] = w.semaphore_mode;
					fail_fast[s] = w.nonblock_mode;
					refs[s] = 8'd1;
					r.slot_out = 4'(s);
					r.status = ST_OK;
				end
			end
		end else if (w.action == ACT_UNUSED || !in_use[w.slot]) begin
			r.status = ST_BAD_SLOT;
		end else begin
			case (w.action)
				ACT_RETAIN: begin
					if (refs[w.slot] < HOLDER_MAX)
						refs[w.slot]++;
				end
				ACT_CLOSE: begin
					if (refs[w.slot] > 8'd1)
						refs[w.slot]--;
					else
						release_slot(w.slot);
				end
				ACT_NONBLOCK: fail_fast[w.slot] = w.nonblock_mode;
				ACT_READ: begin
					if (tally[w.slot] == '0) begin
						r.status = fail_fast[w.slot] ? ST_WOULD_BLOCK : ST_MUST_WAIT;
					end else if (one_at_a_time[w.slot]) begin
						r.read_value = 64'd1;
						tally[w.slot]--;
					end else begin
						r.read_value = tally[w.slot];
						tally[w.slot] = '0;
					end
				end
				ACT_WRITE: begin
					if (w.value > ~tally[w.slot])
						r.status = ST_OVERFLOW;
					else
						tally[w.slot] += w.value;
				end
				default: begin
					interest = (w.poll_mask != 2'b00) ? w.poll_mask : (RDY_READ | RDY_WRITE);
					if (tally[w.slot] != '0 && (interest & RDY_READ) != 2'b00)
						r.ready_mask |= RDY_READ;
					if ((interest & RDY_WRITE) != 2'b00)
						r.ready_mask |= RDY_WRITE;
				end
			endcase
		end
		return r;
	endfunction

	function automatic request_t make_word(logic [2:0] act, logic [3:0] s, logic [63:0] v,
			logic sem, logic nb, logic [1:0] pm);
		request_t w;
		w.action = act;
		w.slot = s;
		w.value = v;
		w.semaphore_mode = sem;
		w.nonblock_mode = nb;
		w.poll_mask = pm;
		return w;
	endfunction

	function automatic logic [3:0] pick_slot();
		int live[$];
		for (int s = 0; s < SLOTS; s++)
			if (in_use[s])
				live.push_back(s);
		if (live.size() == 0 || $urandom_range(0, 99) < 12)
			return 4'($urandom_range(0, SLOTS - 1));
		return 4'(live[$urandom_range(0, live.size() - 1)]);
	endfunction

	function automatic request_t random_word(int create_w, int close_w);
		request_t w;
		int pick;
		logic [63:0] room;
		w = make_word(ACT_POLL, pick_slot(), {$urandom, $urandom}, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		pick = $urandom_range(0, create_w + close_w + 79);
		if (pick < create_w) begin
			w.action = ACT_CREATE;
		end else if (pick < create_w + close_w) begin
			w.action = ACT_CLOSE;
		end else begin
			pick -= create_w + close_w;
			if (pick < 10)
				w.action = ACT_RETAIN;
			else if (pick < 18)
				w.action = ACT_NONBLOCK;
			else if (pick < 40)
				w.action = ACT_READ;
			else if (pick < 64)
				w.action = ACT_WRITE;
			else if (pick < 76)
				w.action = ACT_POLL;
			else
				w.action = ACT_UNUSED;
		end
		room = ~tally[w.slot];
		if (w.action == ACT_WRITE) begin
			case ($urandom_range(0, 3))
				0: w.value = 64'($urandom_range(0, 5));
				1: w.value = {$urandom, $urandom};
				2: w.value = room - 64'($urandom_range(0, 1));
				default: w.value = room + 64'd1;
			endcase
		end else if (w.action == ACT_CREATE && $urandom_range(0, 1) == 1) begin
			w.value = {$urandom, 32'($urandom_range(0, 4))};
		end
		return w;
	endfunction

	task automatic send_word(input request_t w, output result_t r);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= w.action;
		req_if.slot <= w.slot;
		req_if.value <= w.value;
		req_if.semaphore_mode <= w.semaphore_mode;
		req_if.nonblock_mode <= w.nonblock_mode;
		req_if.poll_mask <= w.poll_mask;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		r = bank_apply(w);
		pending_results.push_back(r);
		words_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_create_and_read();
		result_t r;
		logic [3:0] s0;
		logic [3:0] s1;
		send_word(make_word(ACT_CREATE, 4'd9, '1, 1'b0, 1'b1, 2'd0), r);
		s0 = r.slot_out;
		send_word(make_word(ACT_CREATE, 4'd15, '0, 1'b1, 1'b0, 2'd3), r);
		s1 = r.slot_out;
		send_word(make_word(ACT_READ, s1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_NONBLOCK, s1, '1, 1'b1, 1'b1, 2'd1), r);
		send_word(make_word(ACT_READ, s1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_POLL, s1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_WRITE, s1, 64'd3, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_POLL, s1, '0, 1'b0, 1'b0, 2'd1), r);
		send_word(make_word(ACT_READ, s1, '1, 1'b1, 1'b1, 2'd3), r);
		send_word(make_word(ACT_READ, s0, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_POLL, s0, '0, 1'b0, 1'b0, 2'd3), r);
		send_word(make_word(ACT_WRITE, s0, '1, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_WRITE, s0, 64'd1, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_POLL, s0, '0, 1'b0, 1'b0, 2'd2), r);
		send_word(make_word(ACT_POLL, s0, '0, 1'b0, 1'b0, 2'd0), r);
	endtask

	task automatic test_refcount_and_release();
		result_t r;
		send_word(make_word(ACT_RETAIN, 4'd1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_CLOSE, 4'd1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_CLOSE, 4'd1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_READ, 4'd1, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_NONBLOCK, 4'd1, '0, 1'b0, 1'b1, 2'd0), r);
		send_word(make_word(ACT_UNUSED, 4'd0, '1, 1'b1, 1'b1, 2'd3), r);
		send_word(make_word(ACT_POLL, 4'd15, '0, 1'b0, 1'b0, 2'd3), r);
		send_word(make_word(ACT_CLOSE, 4'd0, '0, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_WRITE, 4'd0, 64'd5, 1'b0, 1'b0, 2'd0), r);
		send_word(make_word(ACT_CREATE, 4'd7, 64'hFFFF_FFFF_0000_0002, 1'b1, 1'b0, 2'd0), r);
	endtask

	task automatic test_holder_saturation();
		result_t r;
		logic [3:0] s;
		send_word(make_word(ACT_CREATE, '0, 64'd4, 1'b0, 1'b0, 2'd0), r);
		s = r.slot_out;
		repeat (262)
			send_word(make_word(ACT_RETAIN, s, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))), r);
		repeat (3)
			send_word(make_word(ACT_CLOSE, s, '0, 1'b0, 1'b0, 2'd0), r);
		repeat (3)
			send_word(make_word(ACT_RETAIN, s, '0, 1'b0, 1'b0, 2'd0), r);
	endtask

	task automatic test_random_traffic(int count);
		result_t r;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
				stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
			end
			send_word(random_word(12, 12), r);
		end
		gap_max = 13;
		stall_max = 13;
	endtask

	task automatic test_fill_bank();
		result_t r;
		do begin
			send_word(make_word(ACT_CREATE, 4'($urandom), {$urandom, $urandom},
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'd0), r);
		end while (r.status == ST_OK);
		send_word(make_word(ACT_CREATE, '0, '1, 1'b1, 1'b1, 2'd3), r);
		repeat (120)
			send_word(random_word(2, 30), r);
	endtask

	task automatic test_back_to_back(int count);
		result_t r;
		gap_max = 0;
		stall_max = 0;
		repeat (count)
			send_word(random_word(12, 12), r);
		gap_max = 13;
		stall_max = 13;
	endtask

	initial begin : response_checker
		result_t got;
		result_t want;
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, stall_max);
			@(negedge clk);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			got.status = status_t'(rsp_if.status);
			got.slot_out = rsp_if.slot_out;
			got.read_value = rsp_if.read_value;
			got.ready_mask = rsp_if.ready_mask;
			words_checked++;
			status_seen[rsp_if.status]++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: mismatch: expected no word,", $time,
					" actual status %0d slot %0d value %h mask %0d",
					got.status, got.slot_out, got.read_value, got.ready_mask);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: mismatch: expected status %0d slot %0d value %h mask %0d,",
						$time, want.status, want.slot_out, want.read_value, want.ready_mask,
						" actual status %0d slot %0d value %h mask %0d",
						got.status, got.slot_out, got.read_value, got.ready_mask);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d words outstanding.",
			cycle_count, pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = '0;
		req_if.slot = '0;
		req_if.value = '0;
		req_if.semaphore_mode = 1'b0;
		req_if.nonblock_mode = 1'b0;
		req_if.poll_mask = '0;
		for (int s = 0; s < SLOTS; s++)
			release_slot(s);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_create_and_read();
		test_refcount_and_release();
		wait_drain();
		test_holder_saturation();
		wait_drain();
		test_random_traffic(230);
		wait_drain();
		test_fill_bank();
		wait_drain();
		test_back_to_back(150);
		test_random_traffic(60);
		wait_drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d words and checked %0d responses in %0d cycles, %0d mismatches.",
			words_sent, words_checked, cycle_count, mismatch_count);
		$display("Statuses: ok %0d, no free %0d, bad slot %0d,",
			status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_BAD_SLOT],
			" would block %0d, must wait %0d, overflow %0d.",
			status_seen[ST_WOULD_BLOCK], status_seen[ST_MUST_WAIT], status_seen[ST_OVERFLOW]);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
